// ----- sv/sul_pkg.sv -----
// sul_pkg: command and status codes and the word types of the sorted list
// no dependencies
package sul_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] position;
    logic [3:0] entry_count;
  } out_word_t;

endpackage

// ----- sv/sul_ram.sv -----
// sul_ram: generic single-clock ram, one write port, one read port, registered read
// no dependencies
module sul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/sorted_unique_list.sv -----
// sorted_unique_list: ascending list of distinct signed values kept in one ram
// depends on sul_pkg and sul_ram
//
// A command is taken when start is high and busy is low; busy stays high until
// the command is done, and its one result word appears on out_word for exactly
// one cycle with out_valid, with no way for the receiver to hold it off.
// Entries live in a one-read one-write ram; every step of the scan and of the
// shift costs one ram read (one scan read per entry up to the hit, one move
// per entry above it). Full, empty and unused-code commands answer straight
// from idle without a ram read. No clearing pass is needed.
module sorted_unique_list #(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sul_pkg::in_word_t in_word,
  output logic              out_valid,
  output sul_pkg::out_word_t out_word
);
  import sul_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHUP  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_SHDN  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  in_word_t      req_r, req_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  logic          hit_eq, hit_gt;
  logic          ptr_last;
  logic [AW-1:0] count_top;

  sul_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign hit_eq    = ($signed(rd_data) == $signed(req_r.value));
  assign hit_gt    = ($signed(rd_data) > $signed(req_r.value));
  assign ptr_last  = ((CW'(ptr_r) + CW'(1)) == count_r);
  assign count_top = AW'(count_r - CW'(1));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_word;
          pos_nxt = '0;
          case (in_word.cmd)
            CMD_INSERT: begin
              if (count_r >= CW'(DEPTH)) begin
                out_valid_nxt         = 1'b1;
                out_word_nxt.status   = ST_FULL;
                out_word_nxt.position = '0;
              end else if (count_r == '0) begin
                state_nxt = S_WRITE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            CMD_SEARCH, CMD_REMOVE: begin
              if (count_r == '0) begin
                out_valid_nxt         = 1'b1;
                out_word_nxt.status   = ST_EMPTY;
                out_word_nxt.position = '0;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt         = 1'b1;
              out_word_nxt.status   = ST_MISSING;
              out_word_nxt.position = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit_eq) begin
          if (req_r.cmd == CMD_INSERT) begin
            out_valid_nxt         = 1'b1;
            out_word_nxt.status   = ST_DUP;
            out_word_nxt.position = '0;
            state_nxt             = S_IDLE;
          end else if (req_r.cmd == CMD_REMOVE && !ptr_last) begin
            pos_nxt   = ptr_r;
            rd_en     = 1'b1;
            rd_addr   = ptr_r + AW'(1);
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_SHDN;
          end else begin
            if (req_r.cmd == CMD_REMOVE) begin
              count_nxt = count_r - CW'(1);
            end
            out_valid_nxt         = 1'b1;
            out_word_nxt.status   = ST_OK;
            out_word_nxt.position = 3'(ptr_r);
            state_nxt             = S_IDLE;
          end
        end else if (hit_gt) begin
          if (req_r.cmd == CMD_INSERT) begin
            pos_nxt   = ptr_r;
            rd_en     = 1'b1;
            rd_addr   = count_top;
            ptr_nxt   = count_top;
            state_nxt = S_SHUP;
          end else begin
            out_valid_nxt         = 1'b1;
            out_word_nxt.status   = ST_MISSING;
            out_word_nxt.position = '0;
            state_nxt             = S_IDLE;
          end
        end else if (ptr_last) begin
          if (req_r.cmd == CMD_INSERT) begin
            pos_nxt   = AW'(count_r);
            state_nxt = S_WRITE;
          end else begin
            out_valid_nxt         = 1'b1;
            out_word_nxt.status   = ST_MISSING;
            out_word_nxt.position = '0;
            state_nxt             = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      S_SHUP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r + AW'(1);
        wr_data = rd_data;
        if (ptr_r == pos_r) begin
          state_nxt = S_WRITE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_r - AW'(1);
          ptr_nxt = ptr_r - AW'(1);
        end
      end

      S_WRITE: begin
        wr_en                 = 1'b1;
        wr_addr               = pos_r;
        wr_data               = req_r.value;
        count_nxt             = count_r + CW'(1);
        out_valid_nxt         = 1'b1;
        out_word_nxt.status   = ST_OK;
        out_word_nxt.position = 3'(pos_r);
        state_nxt             = S_IDLE;
      end

      S_SHDN: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r - AW'(1);
        wr_data = rd_data;
        if (ptr_last) begin
          count_nxt             = count_r - CW'(1);
          out_valid_nxt         = 1'b1;
          out_word_nxt.status   = ST_OK;
          out_word_nxt.position = 3'(pos_r);
          state_nxt             = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_word_nxt.entry_count = 4'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r      <= ptr_nxt;
    pos_r      <= pos_nxt;
    req_r      <= req_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) < CW'(DEPTH)))
    else $error("ram write outside the list");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_OK) |-> (out_word_r.position == '0))
    else $error("position not zero on a failed command");

  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid_r)
    else $error("entry count changed without a result word");

endmodule

// ----- test/sul_list_checker.sv -----
// sul_list_checker: watches the command and result channels of sorted_unique_list,
// keeps its own copy of the list to predict every result word and compares them
// depends on sul_pkg
module sul_list_checker #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  sul_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  sul_pkg::out_word_t out_word,
  output int                 pending,
  output int                 errors
);
  timeunit 1ns;
  timeprecision 1ps;

  import sul_pkg::*;

  logic signed [31:0] list_vals [DEPTH];
  int                 list_len;
  out_word_t          answer_q [$];

  function automatic out_word_t apply_list_command(in_word_t w);
    logic signed [31:0] v;
    int                 hit;
    int                 k;
    out_word_t          r;
    v = w.value;
    hit = -1;
    for (k = 0; k < list_len; k++) begin
      if (hit < 0 && list_vals[k] == v) hit = k;
    end
    r.status   = ST_MISSING;
    r.position = '0;
    case (w.cmd)
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (hit >= 0) begin
          r.status = ST_DUP;
        end else begin
          k = list_len;
          while (k > 0 && list_vals[k-1] > v) begin
            list_vals[k] = list_vals[k-1];
            k--;
          end
          list_vals[k] = v;
          list_len++;
          r.status   = ST_OK;
          r.position = 3'(k);
        end
      end
      CMD_SEARCH, CMD_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (hit >= 0) begin
          r.status   = ST_OK;
          r.position = 3'(hit);
          if (w.cmd == CMD_REMOVE) begin
            for (k = hit; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = 4'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    int        bad;
    bad = 0;
    if (!rst_n) begin
      list_len = 0;
      answer_q.delete();
    end else begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result word with none expected: status %0d position %0d count %0d",
                   $time, out_word.status, out_word.position, out_word.entry_count);
          bad++;
        end else begin
          want = answer_q.pop_front();
          if (out_word.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_word.status);
            bad++;
          end
          if (out_word.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     out_word.position);
            bad++;
          end
          if (out_word.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, out_word.entry_count);
            bad++;
          end
        end
      end
      if (start && !busy) answer_q.push_back(apply_list_command(in_word));
    end
    errors  <= errors + bad;
    pending <= answer_q.size();
  end

endmodule

// ----- test/sorted_unique_list_test.sv -----
// sorted_unique_list_test: drives directed and random list commands into
// sorted_unique_list with random gaps and gives the verdict
// depends on sul_pkg, sorted_unique_list and sul_list_checker
module sorted_unique_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sul_pkg::*;

  localparam int DEPTH       = 8;
  localparam int RAND_WORDS  = 500;
  localparam int CYCLE_LIMIT = 250000;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;
  int        pending;
  int        errors;
  int        cycles  = 0;
  bit        burst   = 1'b0;

  sorted_unique_list #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  sul_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_unique_list_test NOT OK");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] value);
    in_word_t w;
    int       gap;
    w.cmd   = cmd;
    w.value = value;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  logic [31:0] pool [10];
  int          sent;
  int          phase;
  int          phase_len;
  int          kind;
  int          pick;
  logic [1:0]  cmd;
  logic [31:0] value;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, unused code, extremes, duplicate, full, removals at both ends
    send_word(CMD_SEARCH, 32'd0);
    send_word(CMD_REMOVE, 32'd5);
    send_word(CMD_UNUSED, 32'd9);
    send_word(CMD_INSERT, 32'd0);
    send_word(CMD_INSERT, 32'h7fff_ffff);
    send_word(CMD_INSERT, 32'h8000_0000);
    send_word(CMD_INSERT, 32'hffff_ffff);
    send_word(CMD_INSERT, 32'd0);
    send_word(CMD_SEARCH, 32'h8000_0000);
    send_word(CMD_SEARCH, 32'h7fff_ffff);
    send_word(CMD_SEARCH, 32'd1);
    send_word(CMD_INSERT, 32'd1);
    send_word(CMD_INSERT, 32'd100);
    send_word(CMD_INSERT, -32'sd100);
    send_word(CMD_INSERT, 32'd2);
    send_word(CMD_INSERT, 32'd3);
    send_word(CMD_INSERT, 32'h7fff_ffff);
    send_word(CMD_UNUSED, 32'd7);
    send_word(CMD_REMOVE, 32'h8000_0000);
    send_word(CMD_REMOVE, 32'h7fff_ffff);
    send_word(CMD_REMOVE, 32'd1);
    send_word(CMD_REMOVE, 32'd12345);
    send_word(CMD_SEARCH, -32'sd100);
    send_word(CMD_INSERT, 32'd12345);
    start <= 1'b0;
    wait_drained();

    sent  = 0;
    phase = 0;
    while (sent < RAND_WORDS) begin
      kind      = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 60);
      burst     = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < 10; i++) begin
        case ($urandom_range(0, 3))
          0: pool[i] = 32'(int'($urandom_range(0, 20)) - 10);
          1: pool[i] = 32'h8000_0000 + $urandom_range(0, 3);
          2: pool[i] = 32'h7fff_ffff - $urandom_range(0, 3);
          default: pool[i] = $urandom;
        endcase
      end
      for (int n = 0; n < phase_len; n++) begin
        pick = $urandom_range(0, 99);
        // kind 0 fills the list, kind 1 drains it, kind 2 mixes
        case (kind)
          0:       cmd = (pick < 70) ? CMD_INSERT : (pick < 90) ? CMD_SEARCH :
                         (pick < 98) ? CMD_REMOVE : CMD_UNUSED;
          1:       cmd = (pick < 15) ? CMD_INSERT : (pick < 35) ? CMD_SEARCH :
                         (pick < 97) ? CMD_REMOVE : CMD_UNUSED;
          default: cmd = (pick < 40) ? CMD_INSERT : (pick < 65) ? CMD_SEARCH :
                         (pick < 95) ? CMD_REMOVE : CMD_UNUSED;
        endcase
        value = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 9)];
        send_word(cmd, value);
        sent++;
      end
      phase++;
      if (phase % 3 == 0) begin
        start <= 1'b0;
        wait_drained();
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (DEPTH + 20) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_unique_list_test OK");
    end else begin
      $display("sorted_unique_list_test NOT OK");
    end
    $finish;
  end

endmodule
